FILE: sv/shortest_path_one_half_price_edge_assert.svh
// assertion macros for the half price edge shortest path block
// used by the top level only, needs i_clk and i_rst_n in scope
`ifndef SHORTEST_PATH_ONE_HALF_PRICE_EDGE_ASSERT_SVH
`define SHORTEST_PATH_ONE_HALF_PRICE_EDGE_ASSERT_SVH

// same cycle implication
`define SPOH_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next cycle implication
`define SPOH_IMPLIES_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/spoh_pkg.sv
// shared types, constants and cost arithmetic for the shortest path block
// no dependencies
package spoh_pkg;

    localparam int NODE_FW = 11;
    localparam int WT_W    = 32;
    localparam int COST_W  = 48;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef struct packed {
        logic [NODE_FW-1:0] src;
        logic [NODE_FW-1:0] dst;
        logic [WT_W-1:0]    wt;
    } t_edge;

    typedef struct packed {
        logic              reached;
        logic              settled;
        logic [COST_W-1:0] cost;
    } t_slot;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [WT_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {{(COST_W+1-WT_W){1'b0}}, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction

endpackage

FILE: sv/spoh_edge_store.sv
// edge store: one write port for loads, one registered read port for the search
// keeps the edge count and the dropped flag; uses spoh_pkg
module spoh_edge_store
    import spoh_pkg::*;
#(
    parameter int MAX_EDGES = 4096,
    parameter int ECW       = 13,
    parameter int EAW       = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ld,
    input  t_edge          i_ld_edge,
    input  logic           i_clr,
    input  logic [EAW-1:0] i_rd_addr,
    output t_edge          o_rd_edge,
    output logic [ECW-1:0] o_total,
    output logic           o_dropped
);

    t_edge          r_mem [MAX_EDGES];
    t_edge          r_rd;
    logic [ECW-1:0] r_total;
    logic           r_dropped;
    logic           w_full;

    assign w_full = (r_total == ECW'(MAX_EDGES));

    always_ff @(posedge i_clk) begin
        if (i_ld && !w_full) begin
            r_mem[r_total[EAW-1:0]] <= i_ld_edge;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_dropped <= 1'b0;
        end else if (i_clr) begin
            r_total   <= '0;
            r_dropped <= 1'b0;
        end else if (i_ld) begin
            if (w_full) begin
                r_dropped <= 1'b1;
            end else begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    assign o_rd_edge = r_rd;
    assign o_total   = r_total;
    assign o_dropped = r_dropped;

endmodule

FILE: sv/spoh_slot_ram.sv
// per node and layer cost memory, one write port and one registered read port
// uses spoh_pkg
module spoh_slot_ram
    import spoh_pkg::*;
#(
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  t_slot         i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output t_slot         o_rd_data
);

    t_slot r_mem [2**AW];
    t_slot r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

FILE: sv/shortest_path_one_half_price_edge.sv
// Edge loads (opcode 0) are accepted while idle and written into the edge store.
// A run request (opcode 1) searches from node 1 to node n over two layers
// (half price unused / used) and returns one result. The run first clears 2(n+1)
// cost slots, then repeats until no open slot is left: a scan of 2(n+1) slots to
// pick the cheapest open slot, a step to settle it and, unless it is node n, a
// pass over the stored edges relaxing those that leave it, at full price in its
// layer and from the first layer at half price into the second; final reads of
// node n follow, and the result waits while an earlier one stalls the output.
// Time per run is set by the single read port of the cost memory.
// Depends on spoh_pkg, spoh_edge_store, spoh_slot_ram and the assertion header.
`include "shortest_path_one_half_price_edge_assert.svh"

module shortest_path_one_half_price_edge
    import spoh_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [NODE_FW-1:0] i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic [NODE_FW-1:0] i_edge_from,
    input  logic [NODE_FW-1:0] i_edge_to,
    input  logic [WT_W-1:0]    i_edge_weight,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [COST_W-1:0]  o_shortest_cost,
    output logic               o_reachable,
    output logic               o_edges_dropped
);

    localparam int NODE_W = $clog2(MAX_NODES + 1);
    localparam int CW     = (NODE_W > NODE_FW) ? NODE_W : NODE_FW;
    localparam int AW     = NODE_W + 1;
    localparam int ECW    = $clog2(MAX_EDGES + 1);
    localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_SCAN, S_SETTLE, S_ERD, S_ECHK, S_R1RD, S_R1WR,
        S_R2RD, S_R2WR, S_F1, S_F2, S_F3, S_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [NODE_FW-1:0]  r_node_count;
    logic [NODE_W-1:0]   r_n, n_n;
    logic                r_lay, n_lay;
    logic [NODE_W-1:0]   r_nod, n_nod;
    logic                r_pend, n_pend;
    logic                r_pend_last, n_pend_last;
    logic [AW-1:0]       r_pend_addr;
    logic                r_issued, n_issued;
    logic                r_found, n_found;
    logic [COST_W-1:0]   r_best, n_best;
    logic [AW-1:0]       r_pick, n_pick;
    logic [ECW-1:0]      r_e, n_e;
    logic [NODE_W-1:0]   r_v, n_v;
    logic [COST_W-1:0]   r_sum_f, n_sum_f;
    logic [COST_W-1:0]   r_sum_h, n_sum_h;
    logic [COST_W-1:0]   r_a_cost, n_a_cost;
    logic                r_a_reach, n_a_reach;
    logic                r_out_valid, n_out_valid;
    logic [COST_W-1:0]   r_out_cost, n_out_cost;
    logic                r_out_reach, n_out_reach;
    logic                r_out_drop, n_out_drop;

    logic                w_ld, w_run, w_clr;
    logic                w_last;
    logic                w_we;
    logic [AW-1:0]       w_wr_addr, w_rd_addr;
    t_slot               w_wr_data, w_rd_slot;
    logic [EAW-1:0]      w_e_addr;
    t_edge               w_edge;
    logic [ECW-1:0]      w_total;
    logic                w_dropped;
    logic                w_cand, w_match, w_relax;
    logic [COST_W-1:0]   w_rcost;
    logic [NODE_W-1:0]   w_n_eff;

    assign w_ld   = i_valid && (r_state == S_IDLE) && !i_opcode;
    assign w_run  = i_valid && (r_state == S_IDLE) && i_opcode;
    assign w_last = r_lay && (r_nod == r_n);
    assign w_cand = w_rd_slot.reached && !w_rd_slot.settled &&
                    (!r_found || (w_rd_slot.cost < r_best));
    assign w_match = (CW'(w_edge.src) == CW'(r_pick[NODE_W-1:0])) &&
                     (w_edge.dst != '0) && (CW'(w_edge.dst) <= CW'(r_n));
    assign w_rcost = (r_state == S_R2WR) ? r_sum_h : r_sum_f;
    assign w_relax = !w_rd_slot.settled && (!w_rd_slot.reached || (w_rcost < w_rd_slot.cost));

    always_comb begin
        if (32'(r_node_count) < 32'd2) begin
            w_n_eff = NODE_W'(2);
        end else if (32'(r_node_count) > 32'(MAX_NODES)) begin
            w_n_eff = NODE_W'(MAX_NODES);
        end else begin
            w_n_eff = NODE_W'(r_node_count);
        end
    end

    // memory port control
    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = {r_lay, r_nod};
        w_wr_data = '{reached: 1'b0, settled: 1'b0, cost: COST_MAX};
        w_rd_addr = {r_lay, r_nod};
        w_e_addr  = r_e[EAW-1:0];
        w_clr     = 1'b0;
        case (r_state)
            S_CLR: begin
                w_we = 1'b1;
                if ({r_lay, r_nod} == AW'(1)) begin
                    w_wr_data = '{reached: 1'b1, settled: 1'b0, cost: '0};
                end
            end
            S_SETTLE: begin
                w_we      = 1'b1;
                w_wr_addr = r_pick;
                w_wr_data = '{reached: 1'b1, settled: 1'b1, cost: r_best};
            end
            S_R1RD: w_rd_addr = {r_pick[NODE_W], r_v};
            S_R1WR: begin
                w_we      = w_relax;
                w_wr_addr = {r_pick[NODE_W], r_v};
                w_wr_data = '{reached: 1'b1, settled: 1'b0, cost: r_sum_f};
            end
            S_R2RD: w_rd_addr = {1'b1, r_v};
            S_R2WR: begin
                w_we      = w_relax;
                w_wr_addr = {1'b1, r_v};
                w_wr_data = '{reached: 1'b1, settled: 1'b0, cost: r_sum_h};
            end
            S_F1: w_rd_addr = {1'b0, r_n};
            S_F2: w_rd_addr = {1'b1, r_n};
            S_OUT: w_clr = !r_out_valid || !i_stall;
            default: ;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_lay       = r_lay;
        n_nod       = r_nod;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_issued    = r_issued;
        n_found     = r_found;
        n_best      = r_best;
        n_pick      = r_pick;
        n_e         = r_e;
        n_v         = r_v;
        n_sum_f     = r_sum_f;
        n_sum_h     = r_sum_h;
        n_a_cost    = r_a_cost;
        n_a_reach   = r_a_reach;
        n_out_valid = r_out_valid && i_stall;
        n_out_cost  = r_out_cost;
        n_out_reach = r_out_reach;
        n_out_drop  = r_out_drop;
        case (r_state)
            S_IDLE: begin
                if (w_run) begin
                    n_n     = w_n_eff;
                    n_lay   = 1'b0;
                    n_nod   = '0;
                    n_state = S_CLR;
                end
            end
            S_CLR, S_SCAN: begin
                if (r_state == S_CLR || !r_issued) begin
                    if (r_nod == r_n) begin
                        n_lay = 1'b1;
                        n_nod = '0;
                    end else begin
                        n_nod = r_nod + 1'b1;
                    end
                end
                if (r_state == S_CLR) begin
                    if (w_last) begin
                        n_state  = S_SCAN;
                        n_lay    = 1'b0;
                        n_nod    = '0;
                        n_issued = 1'b0;
                        n_pend   = 1'b0;
                        n_found  = 1'b0;
                    end
                end else begin
                    n_pend      = !r_issued;
                    n_pend_last = w_last;
                    if (w_last) begin
                        n_issued = 1'b1;
                    end
                    if (r_pend && w_cand) begin
                        n_found = 1'b1;
                        n_best  = w_rd_slot.cost;
                        n_pick  = r_pend_addr;
                    end
                    if (r_pend && r_pend_last) begin
                        n_state = (r_found || w_cand) ? S_SETTLE : S_F1;
                    end
                end
            end
            S_SETTLE: begin
                n_e = '0;
                if (r_pick[NODE_W-1:0] == r_n || w_total == '0) begin
                    n_state  = S_SCAN;
                    n_lay    = 1'b0;
                    n_nod    = '0;
                    n_issued = 1'b0;
                    n_pend   = 1'b0;
                    n_found  = 1'b0;
                end else begin
                    n_state = S_ERD;
                end
            end
            S_ERD: n_state = S_ECHK;
            S_ECHK: begin
                if (w_match) begin
                    n_v     = NODE_W'(w_edge.dst);
                    n_sum_f = sat_add(r_best, w_edge.wt);
                    n_sum_h = sat_add(r_best, {1'b0, w_edge.wt[WT_W-1:1]});
                    n_state = S_R1RD;
                end
            end
            S_R1RD: n_state = S_R1WR;
            S_R1WR: begin
                if (!r_pick[NODE_W]) begin
                    n_state = S_R2RD;
                end
            end
            S_R2RD: n_state = S_R2WR;
            S_F1: n_state = S_F2;
            S_F2: begin
                n_a_cost  = w_rd_slot.reached ? w_rd_slot.cost : COST_MAX;
                n_a_reach = w_rd_slot.reached;
                n_state   = S_F3;
            end
            S_F3: begin
                if (w_rd_slot.reached && (!r_a_reach || w_rd_slot.cost < r_a_cost)) begin
                    n_a_cost = w_rd_slot.cost;
                end
                n_a_reach = r_a_reach || w_rd_slot.reached;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (w_clr) begin
                    n_out_valid = 1'b1;
                    n_out_cost  = r_a_cost;
                    n_out_reach = r_a_reach;
                    n_out_drop  = w_dropped;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // advance to the next edge, or back to the scan after the last one
        if ((r_state == S_ECHK && !w_match) || (r_state == S_R1WR && r_pick[NODE_W]) ||
            r_state == S_R2WR) begin
            if (r_e + 1'b1 == w_total) begin
                n_state  = S_SCAN;
                n_lay    = 1'b0;
                n_nod    = '0;
                n_issued = 1'b0;
                n_pend   = 1'b0;
                n_found  = 1'b0;
            end else begin
                n_e     = r_e + 1'b1;
                n_state = S_ERD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= w_rd_addr;
        r_n         <= n_n;
        r_lay       <= n_lay;
        r_nod       <= n_nod;
        r_pend_last <= n_pend_last;
        r_best      <= n_best;
        r_pick      <= n_pick;
        r_e         <= n_e;
        r_v         <= n_v;
        r_sum_f     <= n_sum_f;
        r_sum_h     <= n_sum_h;
        r_a_cost    <= n_a_cost;
        r_a_reach   <= n_a_reach;
        r_out_cost  <= n_out_cost;
        r_out_reach <= n_out_reach;
        r_out_drop  <= n_out_drop;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= NODE_FW'(2);
            r_pend       <= 1'b0;
            r_issued     <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_issued    <= n_issued;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
        end
    end

    spoh_edge_store #(
        .MAX_EDGES (MAX_EDGES),
        .ECW       (ECW),
        .EAW       (EAW)
    ) u_edge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ld      (w_ld),
        .i_ld_edge ('{src: i_edge_from, dst: i_edge_to, wt: i_edge_weight}),
        .i_clr     (w_clr),
        .i_rd_addr (w_e_addr),
        .o_rd_edge (w_edge),
        .o_total   (w_total),
        .o_dropped (w_dropped)
    );

    spoh_slot_ram #(
        .AW (AW)
    ) u_slot (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_slot)
    );

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_shortest_cost = r_out_cost;
    assign o_reachable     = r_out_reach;
    assign o_edges_dropped = r_out_drop;

    `SPOH_IMPLIES(a_unreach_cost, o_valid && !o_reachable, o_shortest_cost == COST_MAX, "bad cost")
    `SPOH_IMPLIES_NEXT(a_run_clears, w_run, r_state == S_CLR && o_stall, "run did not clear")
    `SPOH_IMPLIES(a_edge_total, 1'b1, 32'(w_total) <= 32'(MAX_EDGES), "edge count too large")

endmodule
